@@ hdl/ule_pkg.sv @@
// shared types, constants and byte-formatting functions for the log escaper
// no dependencies
package ule_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_RUN     = 12;
  localparam int unsigned NUM_TOK     = 4;

  localparam logic [0:0] REG_CONTROL_MODE = 1'd0;
  localparam logic [0:0] REG_UNICODE_MODE = 1'd1;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_CHAR,
    TK_CTRL,
    TK_QMARK,
    TK_CP2,
    TK_CP3,
    TK_CP4
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [20:0] val;
  } tok_t;

  typedef struct packed {
    tok_t [NUM_TOK-1:0] tok;
  } rec_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic control_mode;
    logic unicode_mode;
  } cfg_t;

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [7:0] hex_ch(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h41 + {4'd0, n} - 8'd10);
  endfunction

  function automatic logic [3:0] tok_len(input tok_t tk, input cfg_t cfg);
    logic [3:0] n;
    n = 4'd1;
    case (tk.kind)
      TK_CTRL: begin
        if (cfg.control_mode) begin
          case (tk.val[7:0])
            8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C: n = 4'd2;
            default: n = 4'd4;
          endcase
        end
      end
      TK_CP2: n = cfg.unicode_mode ? 4'd6 : 4'd2;
      TK_CP3: n = cfg.unicode_mode ? 4'd6 : 4'd3;
      TK_CP4: n = cfg.unicode_mode ? 4'd12 : 4'd4;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] u16_byte(input logic [15:0] u, input logic [3:0] j);
    logic [7:0] b;
    case (j)
      4'd0: b = 8'h5C;
      4'd1: b = 8'h75;
      4'd2: b = hex_ch(u[15:12]);
      4'd3: b = hex_ch(u[11:8]);
      4'd4: b = hex_ch(u[7:4]);
      default: b = hex_ch(u[3:0]);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tok_byte(input tok_t tk, input logic [3:0] idx,
                                          input cfg_t cfg);
    logic [7:0]  b;
    logic [20:0] cp;
    logic [19:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    cp = tk.val;
    v  = 20'(cp - 21'h10000);
    hi = {6'b110110, v[19:10]};
    lo = {6'b110111, v[9:0]};
    b  = 8'h3F;
    case (tk.kind)
      TK_CHAR: b = cp[7:0];
      TK_CTRL: begin
        if (!cfg.control_mode) begin
          b = 8'h20;
        end else begin
          case (idx)
            4'd0: b = 8'h5C;
            4'd1: begin
              case (cp[7:0])
                8'h0A: b = 8'h6E;
                8'h0D: b = 8'h72;
                8'h09: b = 8'h74;
                8'h08: b = 8'h62;
                8'h0C: b = 8'h66;
                default: b = 8'h78;
              endcase
            end
            4'd2: b = hex_ch(cp[7:4]);
            default: b = hex_ch(cp[3:0]);
          endcase
        end
      end
      TK_CP2: begin
        if (cfg.unicode_mode) b = u16_byte(cp[15:0], idx);
        else if (idx == 4'd0) b = {3'b110, cp[10:6]};
        else b = {2'b10, cp[5:0]};
      end
      TK_CP3: begin
        if (cfg.unicode_mode) b = u16_byte(cp[15:0], idx);
        else if (idx == 4'd0) b = {4'b1110, cp[15:12]};
        else if (idx == 4'd1) b = {2'b10, cp[11:6]};
        else b = {2'b10, cp[5:0]};
      end
      TK_CP4: begin
        if (cfg.unicode_mode) begin
          // surrogate pair, high half first
          if (idx < 4'd6) b = u16_byte(hi, idx);
          else b = u16_byte(lo, idx - 4'd6);
        end else begin
          case (idx)
            4'd0: b = {5'b11110, cp[20:18]};
            4'd1: b = {2'b10, cp[17:12]};
            4'd2: b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
          endcase
        end
      end
      default: b = 8'h3F;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/ule_front.sv @@
// front end: holds the unfinished sequence and turns each byte into tokens
// depends on ule_pkg
module ule_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  ule_pkg::in_item_t in_item_i,
  output logic              q_push_o,
  output ule_pkg::rec_t     q_data_o,
  input  logic              q_full_i
);

  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  logic [1:0] pcnt_q, pcnt_d;
  logic       halted_q;
  logic       halt_d;
  logic       accept;

  ule_pkg::rec_t rec;
  logic [7:0]    q [8];
  logic [2:0]    len, pos, avail, need;
  logic          done;
  logic [7:0]    c;
  logic          fin;
  ule_pkg::tok_t tk;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;
  assign fin    = in_item_i.msg_end;

  always_comb begin
    for (int k = 0; k < 8; k++) q[k] = 8'd0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pcnt_q) q[k] = pend_q[k];
    end
    q[{1'b0, pcnt_q}] = in_item_i.in_byte;
    len    = {1'b0, pcnt_q} + 3'd1;
    pos    = 3'd0;
    done   = 1'b0;
    rec    = '0;
    pend_d = pend_q;
    pcnt_d = 2'd0;
    halt_d = 1'b0;
    c      = 8'd0;
    avail  = 3'd0;
    need   = 3'd1;
    tk     = '0;
    for (int it = 0; it < ule_pkg::NUM_TOK; it++) begin
      if (!done && pos < len) begin
        c     = q[pos];
        avail = len - 3'd1 - pos;
        tk    = '{kind: ule_pkg::TK_QMARK, val: 21'd0};
        need  = (c < 8'hE0) ? 3'd1 : ((c < 8'hF0) ? 3'd2 : 3'd3);
        if (c < 8'h80) begin
          tk.val = {13'd0, c};
          tk.kind = (c < 8'h20 || c == 8'h7F) ? ule_pkg::TK_CTRL : ule_pkg::TK_CHAR;
          pos = pos + 3'd1;
        end else if (c >= 8'hF8) begin
          // invalid lead: the rest of the message is dropped
          halt_d = !fin;
          done   = 1'b1;
        end else if (avail >= 3'd1 && !ule_pkg::is_cont(q[pos + 3'd1])) begin
          pos = pos + 3'd1;
        end else if (avail < need) begin
          if (fin) begin
            pos = pos + 3'd1;
          end else begin
            for (int k = 0; k < 3; k++) pend_d[k] = q[pos + 3'(k)];
            pcnt_d  = 2'(len - pos);
            tk.kind = ule_pkg::TK_NONE;
            done    = 1'b1;
          end
        end else if (need == 3'd1) begin
          tk = '{kind: ule_pkg::TK_CP2,
                 val: {10'd0, c[4:0], q[pos + 3'd1][5:0]}};
          pos = pos + 3'd2;
        end else if (need == 3'd2) begin
          if (ule_pkg::is_cont(q[pos + 3'd2])) begin
            tk = '{kind: ule_pkg::TK_CP3,
                   val: {5'd0, c[3:0], q[pos + 3'd1][5:0], q[pos + 3'd2][5:0]}};
            pos = pos + 3'd3;
          end else begin
            pos = pos + 3'd2;
          end
        end else begin
          if (!ule_pkg::is_cont(q[pos + 3'd2])) begin
            pos = pos + 3'd2;
          end else if (!ule_pkg::is_cont(q[pos + 3'd3])) begin
            pos = pos + 3'd3;
          end else begin
            tk = '{kind: ule_pkg::TK_CP4,
                   val: {c[2:0], q[pos + 3'd1][5:0], q[pos + 3'd2][5:0],
                         q[pos + 3'd3][5:0]}};
            pos = pos + 3'd4;
          end
        end
        rec.tok[it] = tk;
      end
    end
    if (fin) pcnt_d = 2'd0;
  end

  assign q_data_o = rec;
  assign q_push_o = accept && !halted_q && (rec.tok[0].kind != ule_pkg::TK_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q   <= 2'd0;
      halted_q <= 1'b0;
    end else if (accept) begin
      if (halted_q) begin
        halted_q <= !fin;
        pcnt_q   <= 2'd0;
      end else begin
        halted_q <= halt_d;
        pcnt_q   <= pcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !halted_q) pend_q <= pend_d;
  end

endmodule

@@ hdl/ule_queue.sv @@
// small register queue of token records between front and back
// no dependencies
module ule_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
      if (do_pop)  rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

@@ hdl/ule_back.sv @@
// back end: expands token records into output bytes, one per cycle while pop is high
// depends on ule_pkg
module ule_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ule_pkg::cfg_t      cfg_i,
  input  ule_pkg::rec_t      q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output ule_pkg::out_item_t out_item_o
);

  localparam logic [3:0] RUN_END = 4'(ule_pkg::MAX_RUN - 1);
  localparam logic [1:0] TOK_END = 2'(ule_pkg::NUM_TOK - 1);

  ule_pkg::rec_t cur_q;
  logic          busy_q;
  logic [1:0]    tix_q;
  logic [3:0]    bix_q, cnt_q;
  ule_pkg::tok_t tk;
  logic [3:0]    tlen;
  logic          tok_end, more, last, load;

  always_comb begin
    tk      = cur_q.tok[tix_q];
    tlen    = ule_pkg::tok_len(tk, cfg_i);
    tok_end = bix_q == tlen - 4'd1;
    more    = (tix_q != TOK_END) && (cur_q.tok[tix_q + 2'd1].kind != ule_pkg::TK_NONE);
    // a run is cut after twelve bytes
    last    = (tok_end && !more) || cnt_q == RUN_END;
  end

  assign empty_o             = !busy_q;
  assign out_item_o.out_byte = ule_pkg::tok_byte(tk, bix_q, cfg_i);
  assign out_item_o.run_last = last;
  assign load    = !q_empty_i && (!busy_q || (pop_i && last));
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tix_q  <= 2'd0;
      bix_q  <= 4'd0;
      cnt_q  <= 4'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      tix_q  <= 2'd0;
      bix_q  <= 4'd0;
      cnt_q  <= 4'd0;
    end else if (busy_q && pop_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
        if (tok_end) begin
          tix_q <= tix_q + 2'd1;
          bix_q <= 4'd0;
        end else begin
          bix_q <= bix_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_data_i;
  end

endmodule

@@ hdl/utf8_log_escaper.sv @@
// UTF-8 log escaper: takes one message byte per cycle (push/full) and delivers
// escaped text one byte per cycle (empty/pop). The front end decodes a byte in
// its accept cycle, so plain ASCII flows at one byte per cycle; an expansion
// (escape or re-encoded sequence, up to 12 bytes per input byte) holds the
// result side while its bytes are delivered, and the input keeps flowing
// until the token queue between front and back (QueueDepth records) is full.
module utf8_log_escaper #(
  parameter int unsigned QueueDepth = ule_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ule_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output ule_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [0:0]         cfg_data_i
);

  ule_pkg::cfg_t cfg_q;
  ule_pkg::rec_t f_data, b_data;
  logic          f_push, q_full, q_empty, b_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{control_mode: 1'b1, unicode_mode: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ule_pkg::REG_CONTROL_MODE: cfg_q.control_mode <= cfg_data_i[0];
        ule_pkg::REG_UNICODE_MODE: cfg_q.unicode_mode <= cfg_data_i[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  ule_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_item_i (in_item_i),
    .q_push_o  (f_push),
    .q_data_o  (f_data),
    .q_full_i  (q_full)
  );

  ule_queue #(
    .Width ($bits(ule_pkg::rec_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_data),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (b_data),
    .empty_o (q_empty)
  );

  ule_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_data_i   (b_data),
    .q_empty_i  (q_empty),
    .q_pop_o    (b_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

@@ hdl/ule_checker.sv @@
// port-level checks for the log escaper, bound to the top level
// depends on ule_pkg and utf8_log_escaper
module ule_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input ule_pkg::out_item_t out_item_o
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("output item changed while stalled");

  // a run continues until its last byte
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_item_o.run_last) |=> !empty)
    else $error("run ended without last flag");

  // output drains only after the last byte of a run
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop && out_item_o.run_last))
    else $error("output went empty mid run");

endmodule

bind utf8_log_escaper ule_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
